// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// token codes, error codes, queue entry, divider request and response
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DATA_W      = 32;
  localparam int NUM_VARS    = 8;
  localparam int VAR_IDX_W   = 3;
  localparam int FUNC_W      = 4;
  localparam int ERR_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_LIT = 4'd0,
    FN_PUSH_VAR = 4'd1,
    FN_ADD      = 4'd2,
    FN_SUB      = 4'd3,
    FN_MUL      = 4'd4,
    FN_DIV      = 4'd5,
    FN_EQ       = 4'd6,
    FN_NE       = 4'd7,
    FN_LT       = 4'd8,
    FN_GT       = 4'd9,
    FN_LE       = 4'd10,
    FN_GE       = 4'd11
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CLS_PUSH,
    CLS_OPER,
    CLS_NOP
  } tok_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // classified token as it sits in the queue
  typedef struct packed {
    tok_class_t        cls;
    func_t             func;
    logic [DATA_W-1:0] value;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  // only the first error of an expression is kept
  function automatic err_t keep_first(err_t cur, err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

// ===== hdl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front: token intake
// holds the variable registers, accepts words and classifies each token
// ----------------------------------------------------------------------------
module pse_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pse_pkg::DATA_W-1:0]       cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pse_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic [pse_pkg::FUNC_W-1:0]       s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             q_wr_en,
  output pse_pkg::tok_t                    q_wr_tok,
  input  logic                             q_full
);

  logic [pse_pkg::DATA_W-1:0]    var_value [pse_pkg::NUM_VARS];
  logic [pse_pkg::VAR_IDX_W-1:0] var_idx;
  pse_pkg::func_t                func;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pse_pkg::NUM_VARS; i++) begin
        var_value[i] <= '0;
      end
    end else if (cfg_we) begin
      var_value[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    func           = pse_pkg::func_t'(s_axis_tuser);
    var_idx        = s_axis_tdata[pse_pkg::DATA_W +: pse_pkg::VAR_IDX_W];
    q_wr_tok.func  = func;
    q_wr_tok.last  = s_axis_tlast;
    q_wr_tok.value = s_axis_tdata[pse_pkg::DATA_W-1:0];
    unique case (func) inside
      pse_pkg::FN_PUSH_LIT: q_wr_tok.cls = pse_pkg::CLS_PUSH;
      pse_pkg::FN_PUSH_VAR: begin
        q_wr_tok.cls   = pse_pkg::CLS_PUSH;
        q_wr_tok.value = var_value[var_idx];
      end
      [pse_pkg::FN_ADD:pse_pkg::FN_GE]: q_wr_tok.cls = pse_pkg::CLS_OPER;
      default: q_wr_tok.cls = pse_pkg::CLS_NOP;
    endcase
  end

  assign s_axis_tready = !q_full;
  assign q_wr_en       = s_axis_tvalid && !q_full;

endmodule

// ===== hdl/pse_queue.sv =====
// ----------------------------------------------------------------------------
// pse_queue: short token queue
// decouples intake from execution so either side can stall
// ----------------------------------------------------------------------------
module pse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pse_pkg::tok_t wr_tok,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output pse_pkg::tok_t rd_tok
);

  localparam int PTR_W = $clog2(pse_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pse_pkg::QUEUE_DEPTH + 1);

  pse_pkg::tok_t    entries [pse_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign full     = (count == CNT_W'(pse_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = entries[rd_ptr];

endmodule

// ===== hdl/pse_divider.sv =====
// ----------------------------------------------------------------------------
// pse_divider: signed restoring divider
// one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module pse_divider (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::div_req_t req,
  output pse_pkg::div_rsp_t rsp
);

  localparam int W     = pse_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic             neg;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;

  always_comb begin
    shifted = {rem, quo[W-1]};
    ge      = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // magnitudes in, sign fixed up on the way out
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      quo <= req.dividend[W-1] ? -req.dividend : req.dividend;
      dvs <= req.divisor[W-1] ? -req.divisor : req.divisor;
      neg <= req.dividend[W-1] ^ req.divisor[W-1];
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -quo : quo;

endmodule

// ===== hdl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back: token execution
// operand stack, top-of-stack register, sticky error and result register
// ----------------------------------------------------------------------------
module pse_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  pse_pkg::tok_t                 q_tok,
  output logic                          q_rd_en,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pse_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int W   = pse_pkg::DATA_W;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int PAD = pse_pkg::M_TDATA_W - W - pse_pkg::ERR_W;

  pse_pkg::back_state_t state, state_next;
  pse_pkg::tok_t        item;
  pse_pkg::err_t        sticky, sticky_next;
  pse_pkg::err_t        out_err, out_err_next;
  pse_pkg::div_req_t    div_req;
  pse_pkg::div_rsp_t    div_rsp;

  logic [W-1:0]   mem [STACK_DEPTH];
  logic [SPW-1:0] sp, sp_next, sp_m1, sp_m2;
  logic [W-1:0]   tos, tos_next;
  logic [W-1:0]   rd_b;
  logic           out_valid;
  logic [W-1:0]   out_result, out_result_next;
  logic           load_out;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [W-1:0]   mem_wdata;
  logic           pop;
  logic           stack_full;
  logic           too_few;
  logic           div_by_zero;
  logic signed [W-1:0] ua, ub;
  logic [W-1:0]   alu_res;

  pse_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    sp_m1       = sp - SPW'(1);
    sp_m2       = sp - SPW'(2);
    stack_full  = (sp == SPW'(STACK_DEPTH));
    too_few     = (sp < SPW'(2));
    ua          = tos;
    ub          = rd_b;
    div_by_zero = (ua == '0);
    pop         = (state == pse_pkg::ST_IDLE) && q_valid &&
                  (!q_tok.last || !out_valid || m_axis_tready);
  end

  always_comb begin
    case (item.func)
      pse_pkg::FN_ADD: alu_res = ub + ua;
      pse_pkg::FN_SUB: alu_res = ub - ua;
      pse_pkg::FN_MUL: alu_res = ub * ua;
      pse_pkg::FN_EQ:  alu_res = W'(ub == ua);
      pse_pkg::FN_NE:  alu_res = W'(ub != ua);
      pse_pkg::FN_LT:  alu_res = W'(ub < ua);
      pse_pkg::FN_GT:  alu_res = W'(ub > ua);
      pse_pkg::FN_LE:  alu_res = W'(ub <= ua);
      default:         alu_res = W'(ub >= ua);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::ST_IDLE: begin
        if (pop) begin
          state_next = pse_pkg::ST_EXEC;
        end
      end
      pse_pkg::ST_EXEC: begin
        if (item.cls == pse_pkg::CLS_OPER && !too_few &&
            item.func == pse_pkg::FN_DIV && !div_by_zero) begin
          state_next = pse_pkg::ST_DIV;
        end else if (item.last) begin
          state_next = pse_pkg::ST_EMIT;
        end else begin
          state_next = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = item.last ? pse_pkg::ST_EMIT : pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_EMIT: state_next = pse_pkg::ST_IDLE;
      default: state_next = pse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = sp_m2[AW-1:0];
    mem_wdata        = alu_res;
    sp_next          = sp;
    tos_next         = tos;
    sticky_next      = sticky;
    load_out         = 1'b0;
    out_result_next  = tos;
    out_err_next     = sticky;
    div_req.start    = 1'b0;
    div_req.dividend = ub;
    div_req.divisor  = ua;
    unique case (state)
      pse_pkg::ST_IDLE: ;
      pse_pkg::ST_EXEC: begin
        unique case (item.cls)
          pse_pkg::CLS_PUSH: begin
            if (stack_full) begin
              sticky_next = pse_pkg::keep_first(sticky, pse_pkg::ERR_OVER);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = sp[AW-1:0];
              mem_wdata = item.value;
              tos_next  = item.value;
              sp_next   = sp + SPW'(1);
            end
          end
          pse_pkg::CLS_OPER: begin
            if (too_few) begin
              sticky_next = pse_pkg::keep_first(sticky, pse_pkg::ERR_UNDER);
            end else if (item.func == pse_pkg::FN_DIV) begin
              if (div_by_zero) begin
                sticky_next = pse_pkg::keep_first(sticky, pse_pkg::ERR_DIV0);
                mem_we      = 1'b1;
                mem_wdata   = '0;
                tos_next    = '0;
                sp_next     = sp_m1;
              end else begin
                div_req.start = 1'b1;
              end
            end else begin
              mem_we   = 1'b1;
              tos_next = alu_res;
              sp_next  = sp_m1;
            end
          end
          default: ;
        endcase
      end
      pse_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_rsp.quotient;
          tos_next  = div_rsp.quotient;
          sp_next   = sp_m1;
        end
      end
      pse_pkg::ST_EMIT: begin
        load_out    = 1'b1;
        sp_next     = '0;
        sticky_next = pse_pkg::ERR_NONE;
        if (sp == '0) begin
          out_result_next = '0;
          out_err_next    = pse_pkg::keep_first(sticky, pse_pkg::ERR_UNDER);
        end
      end
      default: ;
    endcase
  end

  // stack storage, second operand read every cycle at sp-2
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_b <= mem[sp_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pse_pkg::ST_IDLE;
      sp        <= '0;
      sticky    <= pse_pkg::ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      sticky <= sticky_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (pop) begin
      item <= q_tok;
    end
    if (load_out) begin
      out_result <= out_result_next;
      out_err    <= out_err_next;
    end
  end

  assign q_rd_en       = pop;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD{1'b0}}, out_err, out_result};

endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: coded postfix expression evaluator
// path: a last token is fetched, executed and emitted before its result
//   word goes out; a divide adds the divider state between execute and emit
// flow: the execution unit takes no new token until the previous one is through;
//   the bit-serial divider sets the slow case
// reset: rst synchronous, active high; clears the variables, stack pointer,
//   sticky error, queue and result valid flag; stack contents are not cleared
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: variable register writes
  input  logic                          cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pse_pkg::DATA_W-1:0]    cfg_data,
  // token stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] literal_value, [34:32] var_index, [39:35] zero
  input  logic [pse_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [3:0] func
  input  logic [pse_pkg::FUNC_W-1:0]    s_axis_tuser,
  // last_token
  input  logic                          s_axis_tlast,
  // result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] result_value, [33:32] error_code, [39:34] zero
  output logic [pse_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // front to queue
  logic          q_wr_en;
  pse_pkg::tok_t q_wr_tok;
  logic          q_full;

  // queue to back
  logic          q_rd_en;
  logic          q_valid;
  pse_pkg::tok_t q_rd_tok;

  // intake: variable registers live here, each word is tagged as a push,
  // an operator or a no-op and lands in the queue in the same cycle
  pse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_wr_en       (q_wr_en),
    .q_wr_tok      (q_wr_tok),
    .q_full        (q_full)
  );

  // two-entry queue lets intake take up to two tokens while a divide runs
  pse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr_en),
    .wr_tok   (q_wr_tok),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_valid (q_valid),
    .rd_tok   (q_rd_tok)
  );

  // execution: stack memory plus a top-of-stack register, so an operator
  // needs only one memory read (the operand below the top)
  pse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_tok         (q_rd_tok),
    .q_rd_en       (q_rd_en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hdl/pse_checker.sv =====
// ----------------------------------------------------------------------------
// pse_checker: port-level checks for the postfix stack evaluator
// watches the stream ports and tracks last tokens against result words
// ----------------------------------------------------------------------------
module pse_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pse_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [3:0] pending;
  logic       in_last;
  logic       out_word;

  assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_word = m_axis_tvalid && m_axis_tready;

  // last tokens taken whose result word has not gone out yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_last && !out_word) begin
      pending <= pending + 4'd1;
    end else if (out_word && !in_last) begin
      pending <= pending - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("result word padding not zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  a_out_has_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 4'd0)
    else $error("result word without a pending last token");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/postfix_stack_evaluator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb: self-checking bench for the postfix evaluator
// feeds coded tokens on the input stream, predicts every result word with a
// behavioral stack machine and compares it field by field on the output
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_tb;

  localparam int DATA_W         = pse_pkg::DATA_W;
  localparam int FUNC_W         = pse_pkg::FUNC_W;
  localparam int VAR_IDX_W      = pse_pkg::VAR_IDX_W;
  localparam int CFG_IDX_W      = pse_pkg::CFG_IDX_W;
  localparam int ERR_W          = pse_pkg::ERR_W;
  localparam int NUM_VARS       = pse_pkg::NUM_VARS;
  localparam int S_TDATA_W      = pse_pkg::S_TDATA_W;
  localparam int M_TDATA_W      = pse_pkg::M_TDATA_W;

  localparam int STACK_DEPTH    = 16;
  localparam int CLK_HALF       = 2;     // ns, 4 ns period
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 200;   // covers queued divides after the last result
  localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake and no variable write
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_TOKENS   = 95;

  // func codes 12..15 are unused and leave the stack alone
  localparam logic [FUNC_W-1:0] FN_SPARE = 4'd15;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic [DATA_W-1:0]    literal;
    logic [VAR_IDX_W-1:0] var_idx;
    logic                 last;
  } token_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    pse_pkg::err_t     code;
  } rpn_result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    token_t            tok;
    bit                typed;
    logic [DATA_W-1:0] want_value;
    pse_pkg::err_t     want_err;
  } step_row_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [DATA_W-1:0]     cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [31:0] literal_value, [34:32] var_index, [39:35] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [3:0] func
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] result_value, [33:32] error_code, [39:34] zero
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  // shadow of the evaluator: variables, operand stack, sticky error
  logic [DATA_W-1:0] var_mirror [NUM_VARS];
  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int unsigned       eval_depth;
  pse_pkg::err_t     eval_err;

  // result words still owed by the block, oldest first
  rpn_result_t pending_results [$];
  step_row_t   directed_steps [$];

  int  tokens_sent      = 0;
  int  expressions_sent = 0;
  int  results_checked  = 0;
  int  flagged_results  = 0;
  int  mismatch_count   = 0;
  int  quiet_cycles     = 0;
  int  hold_tickets     = 0;
  int  holds_served     = 0;
  bit  tx_idle_on       = 1'b1;
  bit  rx_idle_on       = 1'b1;

  always #(CLK_HALF) clk = ~clk;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // stack machine predictor
  // --------------------------------------------------------------------------

  // the first error of an expression sticks until its last token
  function automatic void note_error(input pse_pkg::err_t code);
    if (eval_err == pse_pkg::ERR_NONE) eval_err = code;
  endfunction

  // a push onto a full stack drops the value and flags overflow
  function automatic void push_operand(input logic [DATA_W-1:0] v);
    if (eval_depth >= STACK_DEPTH)
      note_error(pse_pkg::ERR_OVER);
    else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  // applies one token to the shadow state; returns 1 when it owes a result word
  function automatic bit rpn_execute(input token_t tok, output rpn_result_t res);
    logic [DATA_W-1:0] opa, opb, outv;
    longint            sa, sb, quo;
    res.value = '0;
    res.code  = pse_pkg::ERR_NONE;
    if (tok.func == pse_pkg::FN_PUSH_LIT)
      push_operand(tok.literal);
    else if (tok.func == pse_pkg::FN_PUSH_VAR)
      push_operand(var_mirror[tok.var_idx]);
    else if (tok.func <= pse_pkg::FN_GE) begin
      // a is the top, b lies below it, every operator gives b op a
      if (eval_depth < 2)
        note_error(pse_pkg::ERR_UNDER);
      else begin
        opa = eval_stack[eval_depth - 1];
        opb = eval_stack[eval_depth - 2];
        eval_depth -= 2;
        sa   = $signed(opa);
        sb   = $signed(opb);
        outv = '0;
        case (tok.func)
          pse_pkg::FN_ADD: outv = opb + opa;
          pse_pkg::FN_SUB: outv = opb - opa;
          pse_pkg::FN_MUL: outv = opb * opa;
          pse_pkg::FN_DIV: begin
            // divide by zero pops both and pushes zero; the 64-bit quotient
            // makes most-negative over minus one wrap back to most-negative
            if (opa == '0)
              note_error(pse_pkg::ERR_DIV0);
            else begin
              quo  = sb / sa;
              outv = quo[DATA_W-1:0];
            end
          end
          pse_pkg::FN_EQ: outv[0] = (sb == sa);
          pse_pkg::FN_NE: outv[0] = (sb != sa);
          pse_pkg::FN_LT: outv[0] = (sb < sa);
          pse_pkg::FN_GT: outv[0] = (sb > sa);
          pse_pkg::FN_LE: outv[0] = (sb <= sa);
          default:        outv[0] = (sb >= sa);
        endcase
        push_operand(outv);
      end
    end
    if (!tok.last) return 1'b0;
    // an empty stack at the end reads as zero with underflow
    if (eval_depth == 0)
      note_error(pse_pkg::ERR_UNDER);
    else
      res.value = eval_stack[eval_depth - 1];
    res.code   = eval_err;
    eval_depth = 0;
    eval_err   = pse_pkg::ERR_NONE;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_step(input logic [FUNC_W-1:0] func,
                                   input logic [DATA_W-1:0] literal,
                                   input logic [VAR_IDX_W-1:0] var_idx,
                                   input logic last, input bit typed,
                                   input logic [DATA_W-1:0] want_value,
                                   input pse_pkg::err_t want_err);
    step_row_t row;
    row.tok.func    = func;
    row.tok.literal = literal;
    row.tok.var_idx = var_idx;
    row.tok.last    = last;
    row.typed       = typed;
    row.want_value  = want_value;
    row.want_err    = want_err;
    directed_steps.push_back(row);
  endfunction

  // operand values lean toward extremes and small numbers so that wraps,
  // equal compares and zero divisors come up often
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'hffff_ffff;
      default: return $urandom_range(0, 8) - 32'd4;
    endcase
  endfunction

  // unused fields are filled at random too, they must be ignored
  function automatic token_t random_token(input bit operand);
    token_t tok;
    tok.literal = pick_value();
    tok.var_idx = VAR_IDX_W'($urandom_range(0, NUM_VARS - 1));
    tok.last    = 1'b0;
    if (operand)
      tok.func = $urandom_range(0, 1) ? pse_pkg::FN_PUSH_LIT : pse_pkg::FN_PUSH_VAR;
    else begin
      tok.func = FUNC_W'($urandom_range(pse_pkg::FN_ADD, pse_pkg::FN_GE));
      // divides are slow, keep them to about one operator in twenty
      if (tok.func == pse_pkg::FN_DIV && $urandom_range(0, 1) == 0)
        tok.func = pse_pkg::FN_SUB;
    end
    return tok;
  endfunction

  // predicts the token, then offers it until the block takes the word
  task automatic send_token(input token_t tok, input bit typed,
                            input logic [DATA_W-1:0] want_value,
                            input pse_pkg::err_t want_err);
    rpn_result_t res;
    int          gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    if (rpn_execute(tok, res)) begin
      if (typed) begin
        res.value = want_value;
        res.code  = want_err;
      end
      pending_results.push_back(res);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - DATA_W - VAR_IDX_W){1'b0}}, tok.var_idx, tok.literal};
    s_axis_tuser  <= tok.func;
    s_axis_tlast  <= tok.last;
    tokens_sent++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // well-formed postfix expression with random operands and operators;
  // push_first stacks every operand before any operator to reach overflow
  task automatic send_expression(input int operands, input bit push_first);
    token_t tok;
    int     pushed, depth;
    pushed = 0;
    depth  = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || push_first || $urandom_range(0, 2) != 0)) begin
        tok = random_token(1'b1);
        pushed++;
        depth++;
      end else begin
        tok = random_token(1'b0);
        depth--;
      end
      tok.last = (pushed == operands && depth == 1);
      // now and then a stray token of any code breaks the sequence,
      // sometimes ending the expression early
      if ($urandom_range(0, 24) == 0) begin
        tok.func = FUNC_W'($urandom_range(0, 15));
        tok.last = ($urandom_range(0, 3) == 0);
      end
      send_token(tok, 1'b0, '0, pse_pkg::ERR_NONE);
    end
    expressions_sent++;
  endtask

  // registers are only written while the block holds nothing in flight
  task automatic write_variables();
    for (int i = 0; i < NUM_VARS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= var_mirror[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, wait for every owed word, then let tokens with no result
  // (a queued divide at worst) finish inside the block
  task automatic wait_until_quiet();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // receiver pacing: random stall bursts, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : rx_pacing
    forever begin
      @(negedge clk);
      if (holds_served != hold_tickets) begin
        // long hold: the sender keeps offering so the block backs up
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_served++;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else
        m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // result checker and watchdog, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rpn_result_t       want;
    logic [DATA_W-1:0] got_value;
    logic [ERR_W-1:0]  got_err;
    if (rst)
      quiet_cycles = 0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_value = m_axis_tdata[DATA_W-1:0];
        got_err   = m_axis_tdata[DATA_W +: ERR_W];
        results_checked++;
        if (got_err != pse_pkg::ERR_NONE) flagged_results++;
        if (pending_results.size() == 0)
          report_mismatch($sformatf("result word %h / error %0d with none expected",
                                    got_value, got_err));
        else begin
          want = pending_results.pop_front();
          if (got_value !== want.value)
            report_mismatch($sformatf("result_value: expected %h, got %h",
                                      want.value, got_value));
          if (got_err !== want.code)
            report_mismatch($sformatf("error_code: expected %0d, got %0d",
                                      want.code, got_err));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("postfix_stack_evaluator_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int phase_start;
    for (int i = 0; i < NUM_VARS; i++) var_mirror[i] = '0;
    eval_depth = 0;
    eval_err   = pse_pkg::ERR_NONE;

    // directed table, variables still at their reset value of zero
    // unused code as the only token: nothing on the stack, reads as zero
    add_step(FN_SPARE, 32'h1234_5678, 3'd5, 1'b1, 1'b1, '0, pse_pkg::ERR_UNDER);
    // variable seven straight after reset, literal field must be ignored
    add_step(pse_pkg::FN_PUSH_VAR, 32'hffff_ffff, 3'd7, 1'b1, 1'b1, '0, pse_pkg::ERR_NONE);
    // most positive plus one wraps
    add_step(pse_pkg::FN_PUSH_LIT, 32'h7fff_ffff, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0001, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_ADD, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h8000_0000,
             pse_pkg::ERR_NONE);
    // most negative over minus one wraps to most negative
    add_step(pse_pkg::FN_PUSH_LIT, 32'h8000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_DIV, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h8000_0000,
             pse_pkg::ERR_NONE);
    // operator on an empty stack
    add_step(pse_pkg::FN_ADD,      32'h0000_0000, 3'd0, 1'b1, 1'b1, '0, pse_pkg::ERR_UNDER);
    // one long expression: divide by zero first, then every other operator but add
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0005, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_DIV,      32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0001_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0001_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_MUL,      32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_SUB,      32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_VAR, 32'h0000_0000, 3'd3, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_EQ,       32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_NE,       32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0002, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_LT,       32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_GT,       32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0001, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_LE,       32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_PUSH_LIT, 32'h0000_0001, 3'd0, 1'b0, 1'b0, '0, pse_pkg::ERR_NONE);
    add_step(pse_pkg::FN_GE,       32'h0000_0000, 3'd0, 1'b1, 1'b0, '0, pse_pkg::ERR_NONE);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      send_token(directed_steps[i].tok, directed_steps[i].typed,
                 directed_steps[i].want_value, directed_steps[i].want_err);
    wait_until_quiet();

    // random phases, each under a fresh set of variable values
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      if (phase == 1) begin
        var_mirror[0] = 32'h7fff_ffff;
        var_mirror[1] = 32'h8000_0000;
        var_mirror[2] = 32'h0000_0000;
        var_mirror[3] = 32'hffff_ffff;
        var_mirror[4] = 32'h0000_0001;
        var_mirror[5] = 32'h0000_0002;
        var_mirror[6] = $urandom();
        var_mirror[7] = $urandom();
      end else begin
        for (int i = 0; i < NUM_VARS; i++) var_mirror[i] = pick_value();
      end
      write_variables();
      // back-pressure phase: results pile up and the input stalls
      if (phase == 2) hold_tickets++;
      // closing phase runs flat out on both sides
      if (phase == NUM_PHASES) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      phase_start = tokens_sent;
      while (tokens_sent - phase_start < PHASE_TOKENS) begin
        if ($urandom_range(0, 7) == 0)
          send_expression($urandom_range(15, 19), 1'b1);
        else
          send_expression($urandom_range(1, 6), 1'b0);
      end
      wait_until_quiet();
    end

    $display("sent %0d tokens in %0d random expressions under %0d variable settings",
             tokens_sent, expressions_sent, NUM_PHASES + 1);
    $display("checked %0d result words, %0d carried an error code, %0d mismatches",
             results_checked, flagged_results, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("postfix_stack_evaluator_tb OK");
    else
      $display("postfix_stack_evaluator_tb NOT OK");
    $finish;
  end

endmodule
